### hdl/cle_pkg.sv
package cle_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int POS_W      = 5;
    localparam int OP_W       = 3;
    localparam int STAT_W     = 3;
    localparam int DATA_W     = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_TO_START = 3'd2,
        OP_TO_END   = 3'd3,
        OP_BACK     = 3'd4,
        OP_FORWARD  = 3'd5,
        OP_TO_POS   = 3'd6,
        OP_QUERY    = 3'd7
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_AT_END   = 3'd2,
        STAT_AT_START = 3'd3,
        STAT_BAD_POS  = 3'd4,
        STAT_FULL     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FORM,
        S_SEND
    } t_state;

    // Broadcast control for the row of cells.
    typedef struct packed {
        logic                  ins;
        logic                  rem;
        logic [IDX_W-1:0]      pos;
        logic [VALUE_BITS-1:0] item;
    } t_row_ctl;

    // Sign-extends or cuts a stored word to the result width.
    function automatic logic [DATA_W-1:0] to_result(input logic [VALUE_BITS-1:0] v);
        return DATA_W'(signed'(v));
    endfunction

endpackage

### hdl/cle_if.sv
interface cle_in_if;
    logic                          valid;
    logic                          ready;
    logic [cle_pkg::OP_W-1:0]      op;
    logic signed [cle_pkg::DATA_W-1:0] item_value;
    logic [cle_pkg::POS_W-1:0]     target_pos;

    modport source (output valid, output op, output item_value, output target_pos,
                    input ready);
    modport sink   (input valid, input op, input item_value, input target_pos,
                    output ready);
endinterface

interface cle_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [cle_pkg::DATA_W-1:0] result_value;
    logic [cle_pkg::POS_W-1:0]     list_length;
    logic [cle_pkg::POS_W-1:0]     cursor_pos;
    logic [cle_pkg::STAT_W-1:0]    status;

    modport source (output valid, output result_value, output list_length,
                    output cursor_pos, output status, input ready);
    modport sink   (input valid, input result_value, input list_length,
                    input cursor_pos, input status, output ready);
endinterface

### hdl/cle_cell.sv
module cle_cell (
    input  logic                           i_clk,
    input  logic [cle_pkg::IDX_W-1:0]      i_index,
    input  cle_pkg::t_row_ctl              i_ctl,
    input  logic [cle_pkg::VALUE_BITS-1:0] i_left,
    input  logic [cle_pkg::VALUE_BITS-1:0] i_right,
    output logic [cle_pkg::VALUE_BITS-1:0] o_value
);

    logic [cle_pkg::VALUE_BITS-1:0] r_value;
    logic [cle_pkg::VALUE_BITS-1:0] n_value;

    // On insert the cell at the cursor takes the new word and those above it
    // take their lower neighbor; on remove the cells from the cursor up take
    // their upper neighbor.
    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (i_index == i_ctl.pos) begin
                n_value = i_ctl.item;
            end else if (i_index > i_ctl.pos) begin
                n_value = i_left;
            end
        end else if (i_ctl.rem) begin
            if (i_index >= i_ctl.pos) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

### hdl/cle_row.sv
module cle_row (
    input  logic                           i_clk,
    input  cle_pkg::t_row_ctl              i_ctl,
    input  logic [cle_pkg::IDX_W-1:0]      i_rd_idx,
    output logic [cle_pkg::VALUE_BITS-1:0] o_rd_value
);

    logic [cle_pkg::VALUE_BITS-1:0] w_val [cle_pkg::CAPACITY];

    for (genvar g = 0; g < cle_pkg::CAPACITY; g++) begin : g_cell
        logic [cle_pkg::VALUE_BITS-1:0] w_left;
        logic [cle_pkg::VALUE_BITS-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_ctl.item;
        end else begin : g_mid_l
            assign w_left = w_val[g-1];
        end

        if (g == cle_pkg::CAPACITY - 1) begin : g_last
            assign w_right = w_val[g];
        end else begin : g_mid_r
            assign w_right = w_val[g+1];
        end

        cle_cell u_cell (
            .i_clk   (i_clk),
            .i_index (cle_pkg::IDX_W'(g)),
            .i_ctl   (i_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_val[g])
        );
    end

    assign o_rd_value = w_val[i_rd_idx];

endmodule

### hdl/cursor_list_engine.sv
// Channel   Direction  Payload                                          Transfer when
// i_in      sink       op, item_value, target_pos                       valid && ready
// o_out     source     result_value, list_length, cursor_pos, status    valid && ready
//
// The list and cursor change at the input transfer edge, the result is formed
// from the new state in the next cycle and is offered in the one after; the next
// item transfers in the cycle in which that result leaves.
// Reset (i_rst_n low at a clock edge) empties the list and puts the cursor at
// zero; the stored words themselves are not cleared.
// A stalled sink holds the result and blocks further input until it transfers.
module cursor_list_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cle_in_if.sink    i_in,
    cle_out_if.source o_out
);

    // List state. A flagged operation leaves the count and cursor untouched.
    cle_pkg::t_state                r_state;
    cle_pkg::t_state                n_state;
    logic [cle_pkg::POS_W-1:0]      r_count;
    logic [cle_pkg::POS_W-1:0]      n_count;
    logic [cle_pkg::POS_W-1:0]      r_cursor;
    logic [cle_pkg::POS_W-1:0]      n_cursor;

    // Per-item results captured at the transfer edge.
    cle_pkg::t_status               r_stat;
    cle_pkg::t_status               n_stat;
    logic                           r_removed;
    logic                           n_removed;
    logic [cle_pkg::DATA_W-1:0]     r_rem_val;
    logic [cle_pkg::DATA_W-1:0]     n_rem_val;

    // Output register.
    logic [cle_pkg::DATA_W-1:0]     r_res_value;
    logic [cle_pkg::POS_W-1:0]      r_res_len;
    logic [cle_pkg::POS_W-1:0]      r_res_pos;
    cle_pkg::t_status               r_res_stat;

    logic                           w_in_ready;
    logic                           w_accept;
    cle_pkg::t_row_ctl              w_ctl;
    logic [cle_pkg::VALUE_BITS-1:0] w_rd_value;
    logic [cle_pkg::POS_W-1:0]      w_cap;

    assign w_cap = cle_pkg::POS_W'(cle_pkg::CAPACITY);

    // The row is always read at the cursor: before the update this gives the
    // word a remove takes out, after it the word the result reports.
    cle_row u_row (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_rd_idx   (r_cursor[cle_pkg::IDX_W-1:0]),
        .o_rd_value (w_rd_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cle_pkg::S_IDLE;
            r_count   <= '0;
            r_cursor  <= '0;
            r_stat    <= cle_pkg::STAT_OK;
            r_removed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cursor  <= n_cursor;
            r_stat    <= n_stat;
            r_removed <= n_removed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem_val <= n_rem_val;
        if (r_state == cle_pkg::S_FORM) begin
            if (r_removed) begin
                r_res_value <= r_rem_val;
            end else if (r_cursor < r_count) begin
                r_res_value <= cle_pkg::to_result(w_rd_value);
            end else begin
                r_res_value <= '0;
            end
            r_res_len  <= r_count;
            r_res_pos  <= r_cursor;
            r_res_stat <= r_stat;
        end
    end

    always_comb begin
        w_in_ready = (r_state == cle_pkg::S_IDLE) ||
                     ((r_state == cle_pkg::S_SEND) && o_out.ready);
        w_accept   = i_in.valid && w_in_ready;

        n_state   = r_state;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_stat    = r_stat;
        n_removed = r_removed;
        n_rem_val = r_rem_val;

        w_ctl.ins  = 1'b0;
        w_ctl.rem  = 1'b0;
        w_ctl.pos  = r_cursor[cle_pkg::IDX_W-1:0];
        w_ctl.item = cle_pkg::VALUE_BITS'(i_in.item_value);

        case (r_state)
            cle_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = cle_pkg::S_FORM;
                end
            end
            cle_pkg::S_FORM: begin
                n_state = cle_pkg::S_SEND;
            end
            cle_pkg::S_SEND: begin
                if (w_accept) begin
                    n_state = cle_pkg::S_FORM;
                end else if (o_out.ready) begin
                    n_state = cle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cle_pkg::S_IDLE;
            end
        endcase

        if (w_accept) begin
            n_stat    = cle_pkg::STAT_OK;
            n_removed = 1'b0;
            case (cle_pkg::t_op'(i_in.op))
                cle_pkg::OP_INSERT: begin
                    if (r_count >= w_cap) begin
                        n_stat = cle_pkg::STAT_FULL;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + 1'b1;
                    end
                end
                cle_pkg::OP_REMOVE: begin
                    if (r_count == '0) begin
                        n_stat = cle_pkg::STAT_EMPTY;
                    end else if (r_cursor >= r_count) begin
                        n_stat = cle_pkg::STAT_AT_END;
                    end else begin
                        w_ctl.rem = 1'b1;
                        n_removed = 1'b1;
                        n_rem_val = cle_pkg::to_result(w_rd_value);
                        n_count   = r_count - 1'b1;
                    end
                end
                cle_pkg::OP_TO_START: begin
                    n_cursor = '0;
                end
                cle_pkg::OP_TO_END: begin
                    n_cursor = r_count;
                end
                cle_pkg::OP_BACK: begin
                    if (r_cursor == '0) begin
                        n_stat = cle_pkg::STAT_AT_START;
                    end else begin
                        n_cursor = r_cursor - 1'b1;
                    end
                end
                cle_pkg::OP_FORWARD: begin
                    if (r_cursor >= r_count) begin
                        n_stat = cle_pkg::STAT_AT_END;
                    end else begin
                        n_cursor = r_cursor + 1'b1;
                    end
                end
                cle_pkg::OP_TO_POS: begin
                    if (i_in.target_pos > r_count) begin
                        n_stat = cle_pkg::STAT_BAD_POS;
                    end else begin
                        n_cursor = i_in.target_pos;
                    end
                end
                cle_pkg::OP_QUERY: begin
                    if (r_count == '0) begin
                        n_stat = cle_pkg::STAT_EMPTY;
                    end else if (r_cursor >= r_count) begin
                        n_stat = cle_pkg::STAT_AT_END;
                    end
                end
                default: begin
                    n_stat = cle_pkg::STAT_OK;
                end
            endcase
        end
    end

    assign i_in.ready         = w_in_ready;
    assign o_out.valid        = (r_state == cle_pkg::S_SEND);
    assign o_out.result_value = r_res_value;
    assign o_out.list_length  = r_res_len;
    assign o_out.cursor_pos   = r_res_pos;
    assign o_out.status       = r_res_stat;

    // The list never holds more than its capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= w_cap)
        else $error("list count exceeds capacity");

    // The cursor never passes the end of the list.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_count)
        else $error("cursor beyond list end");

    // A successful insert grows the list by exactly one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the list by one");

    // A transfer in is followed by the forming state, then by an offered result.
    a_form_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_out.valid ##1 o_out.valid)
        else $error("result timing after input transfer is wrong");

    // A flagged operation leaves the list length unchanged.
    a_flag_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (n_stat != cle_pkg::STAT_OK)) |=> $stable(r_count))
        else $error("flagged operation changed the list length");

endmodule
